>>> sv/wsdf_pkg.sv
`timescale 1ns / 1ps

package wsdf_pkg;

  // Parser position within a frame
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // Error codes reported in the result
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FRAG_CTL = 2'd1,
    ERR_NON_CONT = 2'd2,
    ERR_LEN_OVF  = 2'd3
  } err_code_t;

  // Frame header constants
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [6:0] LEN16    = 7'd126;

  // Header byte counts for the extended length and the mask key
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES  = 4'd4;

  // One result beat
  typedef struct packed {
    logic [1:0] error_code;
    logic       close_request;
    logic       pong_request;
    logic       last_of_message;
    logic       first_of_message;
    logic       is_control;
    logic [3:0] opcode;
    logic       has_data;
    logic [7:0] out_byte;
  } result_t;

endpackage

>>> sv/websocket_frame_deframer_core.sv
`timescale 1ns / 1ps

// WebSocket receive-side frame parser.
// Bytes of the connection stream enter on the in_ channel, one per beat.
// Frame headers (FIN, opcode, 7/16/64-bit length, optional mask key) are
// consumed silently; each payload byte leaves on the out_ channel unmasked,
// tagged in out_tuser with opcode, control flag, first mark, ping and close
// requests and an error code. out_tlast marks the last beat of a message.
// A frame with no payload produces a single event beat with has_data clear.
// A protocol error produces one beat carrying only the error code; all
// later bytes are accepted and dropped until reset.
// cfg_data[0] (defrag_off) is always accepted; write it only while idle.
// An accepted input beat is held in the input register, and its result, if any,
// is loaded into the output register. Throughput is one byte per cycle while
// the receiver takes results, set by the single parse step between the input
// register and the result register. When the receiver stalls, an empty input
// register still takes one beat, then in_tready drops until the result is taken.
// Synchronous active-low reset returns the parser to the first header byte
// and clears the error and the configuration.
module websocket_frame_deframer_core
  import wsdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data,    // [0] defrag_off
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic [10:0] out_tuser,   // [0] has_data, [4:1] opcode, [5] is_control,
                                   // [6] first_of_message, [7] pong_request,
                                   // [8] close_request, [10:9] error_code
  output logic        out_tlast    // last_of_message
);

  // Registers
  logic        defrag_off_r;
  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        out_v_r;
  result_t     out_r;
  phase_t      phase_r, phase_nxt;
  logic [3:0]  hidx_r, hidx_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic        mask_pres_r, mask_pres_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;
  logic [1:0]  mask_ph_r, mask_ph_nxt;
  logic [63:0] left_r, left_nxt;
  logic        in_frag_r, in_frag_nxt;
  logic [3:0]  msg_op_r, msg_op_nxt;
  logic        started_r, started_nxt;
  logic        err_stop_r, err_stop_nxt;

  // Step control and emit requests
  logic        advance;
  logic        step;
  logic        do_emit;
  logic [7:0]  e_data;
  logic        e_has;
  logic        e_last;
  logic        e_hidx0;
  logic        do_err;
  err_code_t   err_code;
  logic        e_in_msg;
  logic        e_fin_last;
  logic        res_v;
  result_t     res;

  // Combinational temporaries
  logic [6:0]  len7;
  logic [63:0] left_sh;
  logic [63:0] left_dec;
  logic [3:0]  hidx_dec;
  logic [7:0]  key_byte;
  logic        hdr_ctl;
  logic        hdr_fin;
  logic        hdr_frag;

  // Handshakes: the result register advances when empty or taken
  assign advance   = !out_v_r || out_tready;
  assign in_tready = !in_v_r || advance;
  assign step      = in_v_r && advance && !err_stop_r;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.out_byte;
  assign out_tlast  = out_r.last_of_message;
  assign out_tuser  = {out_r.error_code, out_r.close_request, out_r.pong_request,
                       out_r.first_of_message, out_r.is_control, out_r.opcode,
                       out_r.has_data};

  // Shared header arithmetic
  assign len7     = in_byte_r[6:0];
  assign left_sh  = {left_r[55:0], in_byte_r};
  assign left_dec = left_r - 64'd1;
  assign hidx_dec = hidx_r - 4'd1;
  assign hdr_ctl  = in_byte_r[3];
  assign hdr_fin  = in_byte_r[7];
  assign hdr_frag = !hdr_fin || (in_byte_r[3:0] == OP_CONT);

  // A data frame inside an open fragmented message reports the message opcode
  assign e_in_msg   = !flags_r[3] && in_frag_r;
  assign e_fin_last = e_last && flags_r[7];

  // Mask key byte for the current payload position
  always_comb begin
    case (mask_ph_r)
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  // Next parser state
  always_comb begin
    phase_nxt     = phase_r;
    hidx_nxt      = hidx_r;
    flags_nxt     = flags_r;
    mask_pres_nxt = mask_pres_r;
    mask_key_nxt  = mask_key_r;
    mask_ph_nxt   = mask_ph_r;
    left_nxt      = left_r;
    in_frag_nxt   = in_frag_r;
    msg_op_nxt    = msg_op_r;
    started_nxt   = started_r;
    err_stop_nxt  = err_stop_r;
    do_emit       = 1'b0;
    e_data        = 8'd0;
    e_has         = 1'b0;
    e_last        = 1'b0;
    e_hidx0       = 1'b0;
    do_err        = 1'b0;
    err_code      = ERR_NONE;
    if (step) begin
      unique case (phase_r)
        PH_HDR1: begin
          mask_pres_nxt = in_byte_r[7];
          mask_key_nxt  = 32'd0;
          if (len7 < LEN16) begin
            left_nxt = {57'd0, len7};
            if (in_byte_r[7]) begin
              phase_nxt = PH_MASK;
              hidx_nxt  = MASK_BYTES;
            end else begin
              hidx_nxt    = 4'd0;
              mask_ph_nxt = 2'd0;
              if (len7 == 7'd0) begin
                phase_nxt = PH_HDR0;
                do_emit   = 1'b1;
                e_last    = 1'b1;
                e_hidx0   = 1'b1;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end else begin
            left_nxt  = 64'd0;
            phase_nxt = PH_EXTLEN;
            hidx_nxt  = (len7 == LEN16) ? EXT16_BYTES : EXT64_BYTES;
          end
        end
        PH_EXTLEN: begin
          left_nxt = left_sh;
          hidx_nxt = hidx_dec;
          if (hidx_dec == 4'd0) begin
            if (left_sh[63]) begin
              do_err   = 1'b1;
              err_code = ERR_LEN_OVF;
            end else if (mask_pres_r) begin
              phase_nxt = PH_MASK;
              hidx_nxt  = MASK_BYTES;
            end else begin
              mask_ph_nxt = 2'd0;
              if (left_sh == 64'd0) begin
                phase_nxt = PH_HDR0;
                do_emit   = 1'b1;
                e_last    = 1'b1;
                e_hidx0   = 1'b1;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
        end
        PH_MASK: begin
          mask_key_nxt = {mask_key_r[23:0], in_byte_r};
          hidx_nxt     = hidx_dec;
          if (hidx_dec == 4'd0) begin
            mask_ph_nxt = 2'd0;
            if (left_r == 64'd0) begin
              phase_nxt = PH_HDR0;
              do_emit   = 1'b1;
              e_last    = 1'b1;
              e_hidx0   = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          mask_ph_nxt = mask_ph_r + 2'd1;
          left_nxt    = left_dec;
          do_emit     = 1'b1;
          e_has       = 1'b1;
          e_data      = mask_pres_r ? (in_byte_r ^ key_byte) : in_byte_r;
          e_last      = (left_dec == 64'd0);
          e_hidx0     = (hidx_r == 4'd0);
          if (left_dec == 64'd0) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          flags_nxt = in_byte_r;
          phase_nxt = PH_HDR1;
          if (defrag_off_r) begin
            if (!hdr_ctl) begin
              in_frag_nxt = 1'b0;
              started_nxt = 1'b0;
            end
          end else if (hdr_frag && hdr_ctl) begin
            do_err   = 1'b1;
            err_code = ERR_FRAG_CTL;
          end else if (!hdr_ctl && (in_byte_r[3:0] != OP_CONT) && in_frag_r) begin
            do_err   = 1'b1;
            err_code = ERR_NON_CONT;
          end else if (hdr_frag && !in_frag_r) begin
            msg_op_nxt  = in_byte_r[3:0];
            in_frag_nxt = 1'b1;
            started_nxt = 1'b0;
          end
        end
      endcase

      // Message bookkeeping for an emitted beat
      if (do_emit) begin
        hidx_nxt = 4'd1;
        if (e_in_msg) begin
          started_nxt = 1'b1;
          if (e_fin_last) begin
            in_frag_nxt = 1'b0;
            started_nxt = 1'b0;
          end
        end
      end
      if (do_err) begin
        err_stop_nxt = 1'b1;
      end
    end
  end

  // Result beat fields
  always_comb begin
    res   = '0;
    res_v = 1'b0;
    if (do_err) begin
      res_v          = 1'b1;
      res.error_code = err_code;
    end else if (do_emit) begin
      res_v                = 1'b1;
      res.out_byte         = e_data;
      res.has_data         = e_has;
      res.opcode           = e_in_msg ? msg_op_r : flags_r[3:0];
      res.is_control       = flags_r[3];
      res.first_of_message = e_in_msg ? !started_r : e_hidx0;
      res.last_of_message  = e_in_msg ? e_fin_last : e_last;
      res.pong_request     = e_last && (flags_r[3:0] == OP_PING);
      res.close_request    = e_last && (flags_r[3:0] == OP_CLOSE);
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      defrag_off_r <= 1'b0;
      in_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      phase_r      <= PH_HDR0;
      hidx_r       <= 4'd0;
      flags_r      <= 8'd0;
      mask_pres_r  <= 1'b0;
      mask_key_r   <= 32'd0;
      mask_ph_r    <= 2'd0;
      left_r       <= 64'd0;
      in_frag_r    <= 1'b0;
      msg_op_r     <= 4'd0;
      started_r    <= 1'b0;
      err_stop_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        defrag_off_r <= cfg_data[0];
      end
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= step && res_v;
      end
      phase_r     <= phase_nxt;
      hidx_r      <= hidx_nxt;
      flags_r     <= flags_nxt;
      mask_pres_r <= mask_pres_nxt;
      mask_key_r  <= mask_key_nxt;
      mask_ph_r   <= mask_ph_nxt;
      left_r      <= left_nxt;
      in_frag_r   <= in_frag_nxt;
      msg_op_r    <= msg_op_nxt;
      started_r   <= started_nxt;
      err_stop_r  <= err_stop_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (advance) begin
      out_r <= res;
    end
  end

endmodule
